>>> src/p2c_pkg.sv
// ============================================================================
// p2c_pkg
// Shared types and constants for the polar to complex converter: Q30 trig
// formats, Horner-step divisors with their reciprocals, and output limits.
// ============================================================================
package p2c_pkg;

    // Q30 fraction bits and the width of a trig value (one is 2^30)
    localparam int FRAC_W = 30;
    localparam int TRIG_W = 31;

    localparam logic [TRIG_W-1:0] Q30_ONE     = 31'h4000_0000;
    localparam logic [TRIG_W-1:0] HALF_PI_Q30 = 31'd1686629713;
    localparam logic [FRAC_W-1:0] EIGHTH_TURN = 30'h2000_0000;
    localparam logic [FRAC_W-1:0] HALF_LSB    = 30'h2000_0000;

    // Saturation limits of the signed 16-bit result
    localparam logic [15:0] OUT_MAX = 16'h7FFF;
    localparam logic [15:0] OUT_MIN = 16'h8000;
    localparam logic [32:0] MAG_MAX = 33'd32767;

    // Horner chains: three register stages per step
    localparam int STEP_LAT   = 3;
    localparam int SIN_STEPS  = 4;
    localparam int COS_STEPS  = 5;
    localparam int PIPE_DEPTH = COS_STEPS * STEP_LAT + 1;
    localparam int SIN_TAP    = SIN_STEPS * STEP_LAT;

    // Divisors and floor(2^32 / d) reciprocals, innermost term first
    localparam logic [63:0] TWO_POW_32 = 64'h1_0000_0000;
    localparam int DIV_W = 7;

    localparam logic [DIV_W-1:0] SIN_DIV [SIN_STEPS] = '{7'd72, 7'd42, 7'd20, 7'd6};
    localparam logic [DIV_W-1:0] COS_DIV [COS_STEPS] =
        '{7'd90, 7'd56, 7'd30, 7'd12, 7'd2};

    localparam logic [31:0] SIN_RECIP [SIN_STEPS] = '{
        32'(TWO_POW_32 / 72), 32'(TWO_POW_32 / 42),
        32'(TWO_POW_32 / 20), 32'(TWO_POW_32 / 6)
    };
    localparam logic [31:0] COS_RECIP [COS_STEPS] = '{
        32'(TWO_POW_32 / 90), 32'(TWO_POW_32 / 56), 32'(TWO_POW_32 / 30),
        32'(TWO_POW_32 / 12), 32'(TWO_POW_32 / 2)
    };

    // Quadrant of the phase angle
    typedef enum logic [1:0] {
        QUAD_0,
        QUAD_1,
        QUAD_2,
        QUAD_3
    } t_quad;

    // Per-word sideband carried beside the trig pipeline
    typedef struct packed {
        logic  neg;
        t_quad quad;
        logic  swap;
    } t_side;

    // Sign control handed to the scaling stage
    typedef struct packed {
        logic valid;
        logic re_neg;
        logic im_neg;
    } t_scale_ctl;

endpackage

>>> src/p2c_horner_step.sv
// ============================================================================
// p2c_horner_step
// One Horner step t_out = 1 - ((x2 * t_in) >> 30) / d in Q30, over three
// stages: product, reciprocal multiply, remainder correction.
// ============================================================================
module p2c_horner_step
    import p2c_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_en,
    input  logic [FRAC_W-1:0] i_x2,
    input  logic [TRIG_W-1:0] i_t,
    input  logic [31:0]       i_recip,
    input  logic [DIV_W-1:0]  i_div,
    output logic [TRIG_W-1:0] o_t
);

    logic [60:0]       w_prod;
    logic [61:0]       w_qprod;
    logic [FRAC_W-1:0] w_qd;
    logic [FRAC_W-1:0] w_rem;
    logic [FRAC_W-1:0] w_q;

    logic [FRAC_W-1:0] r_p;
    logic [FRAC_W-1:0] r_pb;
    logic [FRAC_W-1:0] r_q0;
    logic [TRIG_W-1:0] r_t;

    logic [FRAC_W-1:0] n_p;
    logic [FRAC_W-1:0] n_q0;
    logic [TRIG_W-1:0] n_t;

    // Stage A: scale t by x2, truncate back to Q30
    assign w_prod = 61'(i_x2) * 61'(i_t);
    assign n_p    = w_prod[59:30];

    // Stage B: quotient estimate, low by at most one
    assign w_qprod = 62'(r_p) * 62'(i_recip);
    assign n_q0    = w_qprod[61:32];

    // Stage C: fix the estimate from the remainder, subtract from one
    assign w_qd  = 30'(37'(r_q0) * 37'(i_div));
    assign w_rem = r_pb - w_qd;
    assign w_q   = r_q0 + 30'(w_rem >= 30'(i_div));
    assign n_t   = Q30_ONE - {1'b0, w_q};

    // Advance all stages together
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p  <= n_p;
            r_pb <= r_p;
            r_q0 <= n_q0;
            r_t  <= n_t;
        end
    end

    assign o_t = r_t;

endmodule

>>> src/p2c_scale.sv
// ============================================================================
// p2c_scale
// Multiplies the amplitude magnitude by both trig magnitudes, then rounds
// half away from zero, applies the sign and saturates to 16 bits.
// ============================================================================
module p2c_scale
    import p2c_pkg::*;
#(
    parameter int AMP_WIDTH = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  t_scale_ctl           i_ctl,
    input  logic [AMP_WIDTH-1:0] i_amag,
    input  logic [TRIG_W-1:0]    i_cmag,
    input  logic [TRIG_W-1:0]    i_smag,
    output logic                 o_valid,
    output logic [15:0]          o_real,
    output logic [15:0]          o_imag
);

    localparam int PW = AMP_WIDTH + TRIG_W;
    localparam int MW = AMP_WIDTH + 1;

    logic [PW-1:0] w_re_prod;
    logic [PW-1:0] w_im_prod;
    logic [PW-1:0] w_re_sum;
    logic [PW-1:0] w_im_sum;
    logic [15:0]   n_real;
    logic [15:0]   n_imag;

    logic          r_v1;
    logic          r_v2;
    logic          r_re_neg;
    logic          r_im_neg;
    logic [PW-1:0] r_re_prod;
    logic [PW-1:0] r_im_prod;
    logic [15:0]   r_real;
    logic [15:0]   r_imag;

    // Signed, saturated 16-bit value from a rounded magnitude
    function automatic logic [15:0] sat16(input logic [MW-1:0] mag, input logic neg);
        logic [32:0] magx;
        logic [15:0] res;
        magx = 33'(mag);
        if (!neg) begin
            res = (magx > MAG_MAX) ? OUT_MAX : magx[15:0];
        end else begin
            res = (magx > MAG_MAX) ? OUT_MIN : 16'(16'd0 - magx[15:0]);
        end
        return res;
    endfunction

    // Stage 1: magnitude products
    assign w_re_prod = PW'(i_amag) * PW'(i_cmag);
    assign w_im_prod = PW'(i_amag) * PW'(i_smag);

    // Stage 2: round from Q30 and saturate
    assign w_re_sum = r_re_prod + PW'(HALF_LSB);
    assign w_im_sum = r_im_prod + PW'(HALF_LSB);
    assign n_real   = sat16(w_re_sum[PW-1:FRAC_W], r_re_neg);
    assign n_imag   = sat16(w_im_sum[PW-1:FRAC_W], r_im_neg);

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_ctl.valid;
            r_v2 <= r_v1;
        end
    end

    // Data
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_re_neg  <= i_ctl.re_neg;
            r_im_neg  <= i_ctl.im_neg;
            r_re_prod <= w_re_prod;
            r_im_prod <= w_im_prod;
            r_real    <= n_real;
            r_imag    <= n_imag;
        end
    end

    assign o_valid = r_v2;
    assign o_real  = r_real;
    assign o_imag  = r_imag;

endmodule

>>> src/polar_to_complex_converter.sv
// ============================================================================
// polar_to_complex_converter
// Streams amplitude/phase words in and returns amp*cos and amp*sin words,
// rounded and saturated to signed 16 bits.
// ============================================================================
// Usage:
//   Input channel: i_valid / o_stall with i_amplitude (signed) and
//   i_phase_angle (binary angle, 2^ANGLE_WIDTH is one turn). A word is taken
//   at a clock edge where i_valid is high and o_stall is low.
//   Output channel: o_valid / i_stall with o_real_part and o_imag_part; a
//   word is delivered at an edge where o_valid is high and i_stall is low.
//   Throughput: one word per cycle while o_stall is low. The pipeline has 22
//   register stages: the cosine Horner chain (five steps of three stages each:
//   product, reciprocal multiply, remainder fix), plus the angle fold, radian
//   and square stages, quadrant select, scaling and the output register.
//   The block keeps no state between words.
//   Reset (synchronous, active low) empties every stage and the output.
//   When the receiver stalls, the finished word holds on the outputs and one
//   more word lands in a skid register; o_stall then rises and the whole
//   pipeline holds until the skid register drains.
// ============================================================================
module polar_to_complex_converter
    import p2c_pkg::*;
#(
    parameter int AMP_WIDTH   = 16,
    parameter int ANGLE_WIDTH = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic signed [AMP_WIDTH-1:0]   i_amplitude,
    input  logic        [ANGLE_WIDTH-1:0] i_phase_angle,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic signed [15:0]            o_real_part,
    output logic signed [15:0]            o_imag_part
);

    logic w_en;
    logic w_out_free;

    // Front stage signals
    logic [AMP_WIDTH-1:0] w_amp_raw;
    logic [63:0]          w_turn_wide;
    logic [31:0]          w_turn;
    logic [FRAC_W-1:0]    w_frac;
    logic [60:0]          w_x_prod;
    logic [59:0]          w_x2_prod;
    t_side                n_s1_side;
    logic [AMP_WIDTH-1:0] n_s1_amag;
    logic [FRAC_W-1:0]    n_s1_arg;

    logic                 r_s1_v;
    t_side                r_s1_side;
    logic [AMP_WIDTH-1:0] r_s1_amag;
    logic [FRAC_W-1:0]    r_s1_arg;

    logic                 r_s2_v;
    t_side                r_s2_side;
    logic [AMP_WIDTH-1:0] r_s2_amag;
    logic [FRAC_W-1:0]    r_s2_x;

    // Delay line beside the Horner chains
    logic                 r_pv    [PIPE_DEPTH];
    t_side                r_pside [PIPE_DEPTH];
    logic [AMP_WIDTH-1:0] r_pamag [PIPE_DEPTH];
    logic [FRAC_W-1:0]    r_px    [PIPE_DEPTH];
    logic [FRAC_W-1:0]    r_px2   [PIPE_DEPTH];

    // Horner chains
    logic [TRIG_W-1:0] w_cos_t [COS_STEPS+1];
    logic [TRIG_W-1:0] w_sin_t [SIN_STEPS+1];
    logic [61:0]       w_sin_prod;
    logic [TRIG_W-1:0] r_sin_m;
    logic [TRIG_W-1:0] r_sin_d1;
    logic [TRIG_W-1:0] r_sin_d2;

    // Quadrant select stage
    logic [TRIG_W-1:0]    w_s;
    logic [TRIG_W-1:0]    w_c;
    logic [TRIG_W-1:0]    n_cmag;
    logic [TRIG_W-1:0]    n_smag;
    t_scale_ctl           n_ctl;
    t_scale_ctl           r_ctl;
    logic [TRIG_W-1:0]    r_cmag;
    logic [TRIG_W-1:0]    r_smag;
    logic [AMP_WIDTH-1:0] r_sel_amag;

    // Tail and output side
    logic        w_tail_v;
    logic [15:0] w_tail_re;
    logic [15:0] w_tail_im;
    logic        r_out_v;
    logic [15:0] r_out_re;
    logic [15:0] r_out_im;
    logic        r_skid_v;
    logic [15:0] r_skid_re;
    logic [15:0] r_skid_im;

    // Pipeline advances unless the skid register holds a word
    assign w_en       = !r_skid_v;
    assign o_stall    = r_skid_v;
    assign w_out_free = !r_out_v || !i_stall;

    // Stage 1: amplitude magnitude, quadrant, fold into the first octant
    assign w_amp_raw   = i_amplitude;
    assign w_turn_wide = 64'(i_phase_angle) << (32 - ANGLE_WIDTH);
    assign w_turn      = w_turn_wide[31:0];
    assign w_frac      = w_turn[FRAC_W-1:0];

    always_comb begin
        n_s1_side.neg  = w_amp_raw[AMP_WIDTH-1];
        n_s1_side.quad = t_quad'(w_turn[31:30]);
        n_s1_side.swap = (w_frac > EIGHTH_TURN);
        n_s1_amag      = n_s1_side.neg ? AMP_WIDTH'(~w_amp_raw + AMP_WIDTH'(1)) : w_amp_raw;
        n_s1_arg       = n_s1_side.swap ? FRAC_W'(Q30_ONE - {1'b0, w_frac}) : w_frac;
    end

    // Stage 2: radians, Q30
    assign w_x_prod = 61'(r_s1_arg) * 61'(HALF_PI_Q30);

    // Stage 3: x squared, Q30
    assign w_x2_prod = 60'(r_s2_x) * 60'(r_s2_x);

    // Valid bits of the front and the delay line
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            for (int i = 0; i < PIPE_DEPTH; i++) begin
                r_pv[i] <= 1'b0;
            end
        end else if (w_en) begin
            r_s1_v  <= i_valid;
            r_s2_v  <= r_s1_v;
            r_pv[0] <= r_s2_v;
            for (int i = 1; i < PIPE_DEPTH; i++) begin
                r_pv[i] <= r_pv[i-1];
            end
        end
    end

    // Front and delay line data
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1_side  <= n_s1_side;
            r_s1_amag  <= n_s1_amag;
            r_s1_arg   <= n_s1_arg;
            r_s2_side  <= r_s1_side;
            r_s2_amag  <= r_s1_amag;
            r_s2_x     <= w_x_prod[59:30];
            r_pside[0] <= r_s2_side;
            r_pamag[0] <= r_s2_amag;
            r_px[0]    <= r_s2_x;
            r_px2[0]   <= w_x2_prod[59:30];
            for (int i = 1; i < PIPE_DEPTH; i++) begin
                r_pside[i] <= r_pside[i-1];
                r_pamag[i] <= r_pamag[i-1];
                r_px[i]    <= r_px[i-1];
                r_px2[i]   <= r_px2[i-1];
            end
        end
    end

    // Cosine series, terms up to x^10
    assign w_cos_t[0] = Q30_ONE;
    for (genvar k = 0; k < COS_STEPS; k++) begin : g_cos
        p2c_horner_step u_step (
            .i_clk   (i_clk),
            .i_en    (w_en),
            .i_x2    (r_px2[k*STEP_LAT]),
            .i_t     (w_cos_t[k]),
            .i_recip (COS_RECIP[k]),
            .i_div   (COS_DIV[k]),
            .o_t     (w_cos_t[k+1])
        );
    end

    // Sine series, terms up to x^9, finished by one multiply by x
    assign w_sin_t[0] = Q30_ONE;
    for (genvar k = 0; k < SIN_STEPS; k++) begin : g_sin
        p2c_horner_step u_step (
            .i_clk   (i_clk),
            .i_en    (w_en),
            .i_x2    (r_px2[k*STEP_LAT]),
            .i_t     (w_sin_t[k]),
            .i_recip (SIN_RECIP[k]),
            .i_div   (SIN_DIV[k]),
            .o_t     (w_sin_t[k+1])
        );
    end

    assign w_sin_prod = 62'(r_px[SIN_TAP]) * 62'(w_sin_t[SIN_STEPS]);

    // Finish sine and delay it to line up with cosine
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sin_m  <= w_sin_prod[60:30];
            r_sin_d1 <= r_sin_m;
            r_sin_d2 <= r_sin_d1;
        end
    end

    // Undo the octant fold, then map by quadrant
    always_comb begin
        w_s = r_pside[PIPE_DEPTH-1].swap ? w_cos_t[COS_STEPS] : r_sin_d2;
        w_c = r_pside[PIPE_DEPTH-1].swap ? r_sin_d2 : w_cos_t[COS_STEPS];
        n_ctl.valid = r_pv[PIPE_DEPTH-1];
        unique case (r_pside[PIPE_DEPTH-1].quad)
            QUAD_0: begin
                n_cmag = w_c;
                n_smag = w_s;
                n_ctl.re_neg = 1'b0;
                n_ctl.im_neg = 1'b0;
            end
            QUAD_1: begin
                n_cmag = w_s;
                n_smag = w_c;
                n_ctl.re_neg = 1'b1;
                n_ctl.im_neg = 1'b0;
            end
            QUAD_2: begin
                n_cmag = w_c;
                n_smag = w_s;
                n_ctl.re_neg = 1'b1;
                n_ctl.im_neg = 1'b1;
            end
            default: begin
                n_cmag = w_s;
                n_smag = w_c;
                n_ctl.re_neg = 1'b0;
                n_ctl.im_neg = 1'b1;
            end
        endcase
        n_ctl.re_neg = n_ctl.re_neg ^ r_pside[PIPE_DEPTH-1].neg;
        n_ctl.im_neg = n_ctl.im_neg ^ r_pside[PIPE_DEPTH-1].neg;
    end

    // Select stage register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (w_en) begin
            r_ctl <= n_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_cmag     <= n_cmag;
            r_smag     <= n_smag;
            r_sel_amag <= r_pamag[PIPE_DEPTH-1];
        end
    end

    // Scale by amplitude, round and saturate
    p2c_scale #(
        .AMP_WIDTH (AMP_WIDTH)
    ) u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_ctl   (r_ctl),
        .i_amag  (r_sel_amag),
        .i_cmag  (r_cmag),
        .i_smag  (r_smag),
        .o_valid (w_tail_v),
        .o_real  (w_tail_re),
        .o_imag  (w_tail_im)
    );

    // Output register and skid: drain skid first, else take the tail word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (r_skid_v) begin
            if (w_out_free) begin
                r_out_v  <= 1'b1;
                r_skid_v <= 1'b0;
            end
        end else if (w_out_free) begin
            r_out_v <= w_tail_v;
        end else if (w_tail_v) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_v) begin
            if (w_out_free) begin
                r_out_re <= r_skid_re;
                r_out_im <= r_skid_im;
            end
        end else if (w_out_free) begin
            r_out_re <= w_tail_re;
            r_out_im <= w_tail_im;
        end else begin
            r_skid_re <= w_tail_re;
            r_skid_im <= w_tail_im;
        end
    end

    assign o_valid     = r_out_v;
    assign o_real_part = r_out_re;
    assign o_imag_part = r_out_im;

endmodule
